>>> sv/psqw_pkg.sv
// Shared types, constants and configuration codes for the proximity switch qualifier.
`default_nettype none
package psqw_pkg;

    // Sizing
    localparam int CHANNELS     = 2;
    localparam int PINS         = 2;
    localparam int AGE_BITS     = 16;
    localparam int SECONDS_BITS = 24;
    localparam int AGE_OUT_BITS = 16;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_LOW   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIRTY_MIN    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_HOURS   = 3'd4;

    localparam int DEBOUNCE_BITS = 8;
    localparam int INTERVAL_BITS = 12;
    localparam int DIRTY_BITS    = 11;
    localparam int IDLE_BITS     = 8;

    // Time conversion
    localparam int SEC_PER_MIN  = 60;
    localparam int SEC_PER_HOUR = 3600;

    // Thresholds in seconds: 2047 * 60 and 255 * 3600 both fit in 20 bits
    localparam int THR_BITS = 20;

    // Reset values
    localparam logic                     ACTIVE_LOW_RESET = 1'b1;
    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET   = 8'd15;
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET   = 12'd60;
    localparam int                       DIRTY_MIN_RESET  = 60;
    localparam int                       IDLE_HOURS_RESET = 24;
    localparam logic [THR_BITS-1:0] DIRTY_THR_RESET = THR_BITS'(DIRTY_MIN_RESET * SEC_PER_MIN);
    localparam logic [THR_BITS-1:0] IDLE_THR_RESET  = THR_BITS'(IDLE_HOURS_RESET * SEC_PER_HOUR);

    // Compare width for totals against thresholds
    localparam int CMP_BITS = (SECONDS_BITS > THR_BITS) ? SECONDS_BITS : THR_BITS;
    // Compare width for age against the output ceiling
    localparam int AGE_CMP_BITS = (AGE_BITS > AGE_OUT_BITS) ? AGE_BITS : AGE_OUT_BITS;

    typedef struct packed {
        logic                     active_low;
        logic [DEBOUNCE_BITS-1:0] debounce;
        logic [INTERVAL_BITS-1:0] interval;
        logic [THR_BITS-1:0]      dirty_thr;
        logic [THR_BITS-1:0]      idle_thr;
    } cfg_t;

    typedef struct packed {
        logic seed;
        logic consume;
        logic record_strobe;
        logic clear_watch;
    } strobe_t;

    typedef struct packed {
        logic                    active;
        logic                    changed;
        logic [AGE_OUT_BITS-1:0] age;
        logic                    dirty;
        logic                    idle;
    } chan_res_t;

endpackage : psqw_pkg
`default_nettype wire

>>> sv/psqw_cfg.sv
// Configuration registers with precomputed dirty and idle thresholds in seconds.
`default_nettype none
module psqw_cfg
    import psqw_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_LOW: cfg_next.active_low = cfg_data[0];
                CFG_DEBOUNCE:   cfg_next.debounce   = cfg_data[DEBOUNCE_BITS-1:0];
                CFG_INTERVAL:   cfg_next.interval   = cfg_data[INTERVAL_BITS-1:0];
                CFG_DIRTY_MIN:  cfg_next.dirty_thr  =
                    THR_BITS'(cfg_data[DIRTY_BITS-1:0]) * THR_BITS'(SEC_PER_MIN);
                CFG_IDLE_HOURS: cfg_next.idle_thr   =
                    THR_BITS'(cfg_data[IDLE_BITS-1:0]) * THR_BITS'(SEC_PER_HOUR);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_low <= ACTIVE_LOW_RESET;
            cfg_reg.debounce   <= DEBOUNCE_RESET;
            cfg_reg.interval   <= INTERVAL_RESET;
            cfg_reg.dirty_thr  <= DIRTY_THR_RESET;
            cfg_reg.idle_thr   <= IDLE_THR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : psqw_cfg
`default_nettype wire

>>> sv/psqw_chan.sv
// One channel: edge lockout debounce, change flag, edge age and activity watchdog.
`default_nettype none
module psqw_chan
    import psqw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire logic pin,
    input  strobe_t   strobes,
    input  cfg_t      cfg,
    output chan_res_t res
);

    logic                    level_reg, level_next;
    logic                    prev_raw_reg, prev_raw_next;
    logic                    pending_reg, pending_next;
    logic [AGE_BITS-1:0]     age_reg, age_next;
    logic [SECONDS_BITS-1:0] act_sec_reg, act_sec_next;
    logic [SECONDS_BITS-1:0] inact_sec_reg, inact_sec_next;
    logic                    dirty_reg, dirty_next;
    logic                    idle_reg, idle_next;

    logic                    mapped;
    logic [AGE_BITS-1:0]     age_inc;
    logic                    edge_ok;
    logic [SECONDS_BITS:0]   act_sum;
    logic [SECONDS_BITS:0]   inact_sum;
    logic [SECONDS_BITS-1:0] act_sat;
    logic [SECONDS_BITS-1:0] inact_sat;
    logic [AGE_CMP_BITS-1:0] age_wide;
    logic                    changed_out;

    assign mapped  = cfg.active_low ? ~pin : pin;
    assign age_inc = (&age_reg) ? age_reg : age_reg + AGE_BITS'(1);
    assign edge_ok = (pin != prev_raw_reg)
                   && (age_inc >= AGE_BITS'(cfg.debounce))
                   && (mapped != level_reg);

    assign act_sum   = {1'b0, act_sec_reg} + (SECONDS_BITS + 1)'(cfg.interval);
    assign inact_sum = {1'b0, inact_sec_reg} + (SECONDS_BITS + 1)'(cfg.interval);
    assign act_sat   = act_sum[SECONDS_BITS] ? '1 : act_sum[SECONDS_BITS-1:0];
    assign inact_sat = inact_sum[SECONDS_BITS] ? '1 : inact_sum[SECONDS_BITS-1:0];

    always_comb
    begin
        level_next     = level_reg;
        pending_next   = pending_reg;
        age_next       = age_inc;
        act_sec_next   = act_sec_reg;
        inact_sec_next = inact_sec_reg;
        dirty_next     = dirty_reg;
        idle_next      = idle_reg;
        prev_raw_next  = pin;

        // Seed wins over edge evaluation
        priority if (strobes.seed)
        begin
            level_next   = mapped;
            pending_next = 1'b0;
            age_next     = '0;
        end
        else if (edge_ok)
        begin
            level_next   = mapped;
            pending_next = 1'b1;
            age_next     = '0;
        end
        else
        begin
            level_next   = level_reg;
        end

        if (strobes.record_strobe)
        begin
            if (level_next)
            begin
                act_sec_next   = act_sat;
                inact_sec_next = '0;
                idle_next      = 1'b0;
                dirty_next     = CMP_BITS'(act_sat) >= CMP_BITS'(cfg.dirty_thr);
            end
            else
            begin
                act_sec_next   = '0;
                dirty_next     = 1'b0;
                inact_sec_next = inact_sat;
                idle_next      = CMP_BITS'(inact_sat) >= CMP_BITS'(cfg.idle_thr);
            end
        end

        if (strobes.clear_watch)
        begin
            act_sec_next   = '0;
            inact_sec_next = '0;
            dirty_next     = 1'b0;
            idle_next      = 1'b0;
        end

        changed_out = strobes.consume & pending_next;
        if (strobes.consume)
        begin
            pending_next = 1'b0;
        end
    end

    assign age_wide    = AGE_CMP_BITS'(age_next);
    assign res.active  = level_next;
    assign res.changed = changed_out;
    assign res.age     = (age_wide > AGE_CMP_BITS'({AGE_OUT_BITS{1'b1}}))
                       ? {AGE_OUT_BITS{1'b1}} : age_wide[AGE_OUT_BITS-1:0];
    assign res.dirty   = dirty_next;
    assign res.idle    = idle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= 1'b0;
            prev_raw_reg  <= 1'b1;
            pending_reg   <= 1'b0;
            age_reg       <= '0;
            act_sec_reg   <= '0;
            inact_sec_reg <= '0;
            dirty_reg     <= 1'b0;
            idle_reg      <= 1'b0;
        end
        else if (advance)
        begin
            level_reg     <= level_next;
            prev_raw_reg  <= prev_raw_next;
            pending_reg   <= pending_next;
            age_reg       <= age_next;
            act_sec_reg   <= act_sec_next;
            inact_sec_reg <= inact_sec_next;
            dirty_reg     <= dirty_next;
            idle_reg      <= idle_next;
        end
    end

endmodule : psqw_chan
`default_nettype wire

>>> sv/proximity_switch_qualifier_watchdog.sv
// Top level of the two-channel proximity switch qualifier with stuck and idle watchdog.
// Each input transfer is one millisecond tick carrying both raw pin levels and the seed,
// consume, record and clear strobes; each tick yields exactly one result transfer. The
// tick is captured in an input register, all per-channel work (polarity mapping, edge
// lockout against debounce_ms, change flag, edge age, saturating activity totals and the
// dirty and idle compares) is done in one pass of logic, and the result lands in an output
// register. The block takes one tick per clock cycle while the output is not stalled; each tick
// passes through the input register and then the output register. A stalled output holds its
// result while one more tick waits in the input register, so the input side stalls only when
// both registers are full. Write the configuration registers only while no tick is in flight;
// thresholds in seconds are computed at write time.
`default_nettype none
module proximity_switch_qualifier_watchdog
    import psqw_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     pin_a,
    input  wire logic                     pin_b,
    input  wire logic                     seed,
    input  wire logic                     consume,
    input  wire logic                     record_strobe,
    input  wire logic                     clear_watch,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          active_a,
    output logic                          active_b,
    output logic                          changed_a,
    output logic                          changed_b,
    output logic [AGE_OUT_BITS-1:0]       age_a,
    output logic [AGE_OUT_BITS-1:0]       age_b,
    output logic                          dirty_a,
    output logic                          dirty_b,
    output logic                          idle_a,
    output logic                          idle_b
);

    cfg_t cfg;

    // Input stage
    logic            in_vld_reg, in_vld_next;
    logic [PINS-1:0] pins_reg;
    strobe_t         strobes_reg;

    // Output stage
    logic            out_vld_reg, out_vld_next;
    chan_res_t       res_reg [PINS];

    chan_res_t       res     [PINS];
    logic            in_xfer;
    logic            advance;

    psqw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the held tick whenever the output register is free or being drained
    assign advance  = in_vld_reg && !(out_vld_reg && out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    assign in_vld_next  = in_xfer || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the tick payload on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pins_reg                  <= {pin_b, pin_a};
            strobes_reg.seed          <= seed;
            strobes_reg.consume       <= consume;
            strobes_reg.record_strobe <= record_strobe;
            strobes_reg.clear_watch   <= clear_watch;
        end
    end

    // One qualifier per pin; pins beyond the channel count report zero
    for (genvar c = 0; c < PINS; c++)
    begin : g_chan
        if (c < CHANNELS)
        begin : g_used
            psqw_chan u_chan (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .pin     (pins_reg[c]),
                .strobes (strobes_reg),
                .cfg     (cfg),
                .res     (res[c])
            );
        end
        else
        begin : g_unused
            assign res[c] = '0;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                res_reg[c] <= res[c];
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign active_a  = res_reg[0].active;
    assign active_b  = res_reg[1].active;
    assign changed_a = res_reg[0].changed;
    assign changed_b = res_reg[1].changed;
    assign age_a     = res_reg[0].age;
    assign age_b     = res_reg[1].age;
    assign dirty_a   = res_reg[0].dirty;
    assign dirty_b   = res_reg[1].dirty;
    assign idle_a    = res_reg[0].idle;
    assign idle_b    = res_reg[1].idle;

endmodule : proximity_switch_qualifier_watchdog
`default_nettype wire
